// ----- hdl/eth_hdr_pkg.sv -----
package eth_hdr_pkg;

    // length counter width, frame and payload lengths share it
    localparam int LEN_BITS = 14;

    typedef logic [LEN_BITS-1:0] len_t;

    localparam len_t LEN_MAX = len_t'((1 << LEN_BITS) - 1);

    // byte positions where each header field ends
    localparam len_t DEST_END   = len_t'(6);
    localparam len_t SOURCE_END = len_t'(12);
    localparam len_t OUTER_END  = len_t'(14);
    localparam len_t TCI_END    = len_t'(16);
    localparam len_t INNER_END  = len_t'(18);

    localparam logic [15:0] TPID_8021Q = 16'h8100;

    localparam logic [4:0] HDR_PLAIN  = 5'd14;
    localparam logic [4:0] HDR_TAGGED = 5'd18;

    localparam len_t MIN_PAYLOAD_TAGGED = len_t'(42);
    localparam len_t MIN_PAYLOAD_PLAIN  = len_t'(46);

    localparam len_t MIN_FRAME_RESET = len_t'(60);
    localparam len_t MAX_FRAME_RESET = len_t'(1500);

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 8;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    localparam cfg_index_t CFG_MIN_FRAME_LEN = cfg_index_t'(0);
    localparam cfg_index_t CFG_MAX_FRAME_LEN = cfg_index_t'(1);

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_LEN_RANGE = 2'd1,
        STATUS_TAG_TRUNC = 2'd2,
        STATUS_PAY_SHORT = 2'd3
    } status_t;

    // result item packed into tdata, first field lowest
    localparam int RESULT_BITS = 48 + 48 + 16 + 32 + 5 + 2 * LEN_BITS + 2;
    localparam int RESULT_TDATA_W = ((RESULT_BITS + 7) / 8) * 8;
    localparam int RESULT_PAD_W = RESULT_TDATA_W - RESULT_BITS;

    typedef logic [RESULT_TDATA_W-1:0] result_tdata_t;

endpackage

// ----- hdl/ethernet_header_parser_top.sv -----
// channel     | direction | handshake          | payload
// ------------+-----------+--------------------+------------------------------------------
// s_axis      | in        | s_tvalid/s_tready  | s_tdata = data_byte, s_tlast = last_byte
// m_axis      | out       | m_tvalid/m_tready  | m_tdata = header fields, m_tuser = is_tagged
// cfg         | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (min/max frame length)
//
// one byte per cycle while no result waits for m_tready; each byte passes through the input register and
// the last byte of a frame loads the result register as it leaves, so m_tvalid
// rises once the last byte has left the input register for the result register
// rst_n low (asynchronous) empties both registers, clears the frame state and
// loads min_frame_len = 60, max_frame_len = 1500
// a waiting result holds the next byte until m_tready; cfg_ready is tied high
module ethernet_header_parser_top (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,    // data_byte[7:0]
    input  logic                         s_tlast,    // last_byte

    output logic                         m_tvalid,
    input  logic                         m_tready,
    // dest_mac[47:0], src_mac[95:48], ether_kind[111:96], vlan_word[143:112],
    // header_len[148:144], payload_bytes[162:149], frame_len[176:163],
    // status[178:177], zero pad[183:179]
    output eth_hdr_pkg::result_tdata_t   m_tdata,
    output logic                         m_tuser,    // is_tagged

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  eth_hdr_pkg::cfg_index_t      cfg_index,
    input  eth_hdr_pkg::len_t            cfg_data
);

    import eth_hdr_pkg::*;

    // configuration
    len_t min_len_reg;
    len_t max_len_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // per-frame header state
    len_t        count_reg,  count_next;
    logic [47:0] dest_reg,   dest_next;
    logic [47:0] source_reg, source_next;
    logic [15:0] outer_reg,  outer_next;
    logic [15:0] tci_reg,    tci_next;
    logic [15:0] inner_reg,  inner_next;

    // output register
    logic          out_valid_reg;
    result_tdata_t out_data_reg, out_data_next;
    logic          out_tag_reg,  out_tag_next;

    logic    advance;
    logic    consume;
    len_t    count_inc;
    logic    vlan_hit;
    logic [4:0] hdr_len;
    len_t    hdr_len_ext;
    len_t    pay_len;
    status_t status;

    assign cfg_ready = 1'b1;

    // the byte in the input register moves on unless a result is stuck
    assign advance  = !out_valid_reg || m_tready;
    assign consume  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= MIN_FRAME_RESET;
            max_len_reg <= MAX_FRAME_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MIN_FRAME_LEN: min_len_reg <= cfg_data;
                CFG_MAX_FRAME_LEN: max_len_reg <= cfg_data;
                default:           ;  // unknown index, ignored
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // header capture: each byte shifts into the field its position belongs to
    always_comb
    begin
        dest_next   = dest_reg;
        source_next = source_reg;
        outer_next  = outer_reg;
        tci_next    = tci_reg;
        inner_next  = inner_reg;

        if (count_reg < DEST_END)
        begin
            dest_next = {dest_reg[39:0], in_byte_reg};
        end
        else if (count_reg < SOURCE_END)
        begin
            source_next = {source_reg[39:0], in_byte_reg};
        end
        else if (count_reg < OUTER_END)
        begin
            outer_next = {outer_reg[7:0], in_byte_reg};
        end
        else if (count_reg < TCI_END)
        begin
            tci_next = {tci_reg[7:0], in_byte_reg};
        end
        else if (count_reg < INNER_END)
        begin
            inner_next = {inner_reg[7:0], in_byte_reg};
        end

        // saturating byte counter
        count_inc  = (count_reg == LEN_MAX) ? count_reg : count_reg + len_t'(1);
        count_next = in_last_reg ? '0 : count_inc;
    end

    // result of the frame, built from the state including the current byte
    always_comb
    begin
        vlan_hit    = (outer_next == TPID_8021Q);
        hdr_len     = vlan_hit ? HDR_TAGGED : HDR_PLAIN;
        hdr_len_ext = len_t'(hdr_len);
        pay_len     = (count_inc > hdr_len_ext) ? count_inc - hdr_len_ext : '0;

        if (count_inc < min_len_reg || count_inc > max_len_reg)
        begin
            status = STATUS_LEN_RANGE;
        end
        else if (vlan_hit && count_inc < INNER_END)
        begin
            status = STATUS_TAG_TRUNC;
        end
        else if (pay_len < MIN_PAYLOAD_TAGGED || (!vlan_hit && pay_len < MIN_PAYLOAD_PLAIN))
        begin
            status = STATUS_PAY_SHORT;
        end
        else
        begin
            status = STATUS_OK;
        end

        out_data_next = {
            {RESULT_PAD_W{1'b0}},
            status,
            count_inc,
            pay_len,
            hdr_len,
            vlan_hit ? {outer_next, tci_next} : 32'd0,
            vlan_hit ? inner_next : outer_next,
            source_next,
            dest_next
        };
        out_tag_next = vlan_hit;
    end

    // frame state, cleared after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            dest_reg   <= '0;
            source_reg <= '0;
            outer_reg  <= '0;
            tci_reg    <= '0;
            inner_reg  <= '0;
        end
        else if (consume)
        begin
            count_reg <= count_next;
            if (in_last_reg)
            begin
                dest_reg   <= '0;
                source_reg <= '0;
                outer_reg  <= '0;
                tci_reg    <= '0;
                inner_reg  <= '0;
            end
            else
            begin
                dest_reg   <= dest_next;
                source_reg <= source_next;
                outer_reg  <= outer_next;
                tci_reg    <= tci_next;
                inner_reg  <= inner_next;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= consume && in_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && in_last_reg)
        begin
            out_data_reg <= out_data_next;
            out_tag_reg  <= out_tag_next;
        end
    end

endmodule
